FILE: sv/ovle_pkg.sv
// Shared types and constants for the ordered value list engine.
// No dependencies; imported by ovle_seq and the top level.
package ovle_pkg;

  localparam int unsigned DEPTH_DEF   = 16;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned OP_W        = 3;
  localparam int unsigned COUNT_OUT_W = 5;
  localparam int unsigned IN_TDATA_W  = 72;  // 3 + 32 + 32 = 67, padded to bytes
  localparam int unsigned OUT_TDATA_W = 8;   // 2 + 1 + 5

  typedef enum logic [OP_W-1:0] {
    OP_APPEND      = 3'd0,
    OP_REMOVE_HEAD = 3'd1,
    OP_REMOVE_TAIL = 3'd2,
    OP_DELETE_KEY  = 3'd3,
    OP_FIND_KEY    = 3'd4,
    OP_REPLACE_KEY = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_APPEND,
    S_READ,
    S_CMP,
    S_UNLINK,
    S_FIN
  } seq_state_e;

  // Result of one operation, handed from the sequencer to the output stage.
  typedef struct packed {
    status_e                status;
    logic                   hit;
    logic [COUNT_OUT_W-1:0] count;
  } result_t;

endpackage

FILE: sv/ovle_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ovle_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/ovle_seq.sv
// Sequencer of the list engine: list registers, the value/link/free-slot RAMs
// and the FSM that walks them. Depends on ovle_pkg and ovle_ram.
module ovle_seq
  import ovle_pkg::*;
#(
  parameter int unsigned Depth = DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  op_e               op_i,
  input  logic [DATA_W-1:0] operand_value_i,
  input  logic [DATA_W-1:0] new_value_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output result_t           res_o
);

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(Depth);
  localparam logic [CW-1:0] ONE      = CW'(1);

  seq_state_e state_q, state_d;
  op_e        op_q;
  logic [DATA_W-1:0] key_q, newv_q;
  logic [AW-1:0] cur_q, cur_d, head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] count_q, count_d, k_q, k_d, sp_q, sp_d, fresh_q, fresh_d;
  status_e status_q, status_d;
  logic    hit_q, hit_d;

  // RAM ports
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] val_rd, val_wdata;
  logic [AW-1:0]     val_waddr;
  logic              val_we;
  logic [AW-1:0]     next_rd, next_waddr, next_wdata;
  logic              next_we;
  logic [AW-1:0]     prior_rd, prior_waddr, prior_wdata;
  logic              prior_we;
  logic [AW-1:0]     stk_rd, stk_raddr;
  logic              stk_we;

  logic          accept, match, last, empty;
  logic [AW-1:0] slot;

  assign accept = in_valid_i && in_ready_o;
  assign empty  = (count_q == '0);
  assign match  = (val_rd == key_q);
  assign last   = ((k_q + ONE) == count_q);
  assign slot   = (sp_q != '0) ? stk_rd : fresh_q[AW-1:0];
  assign stk_raddr = AW'(sp_q - ONE);

  ovle_ram #(.Width(DATA_W), .Depth(Depth)) u_val_ram (
    .clk_i, .we_i(val_we), .waddr_i(val_waddr), .wdata_i(val_wdata),
    .raddr_i(rd_addr), .rdata_o(val_rd)
  );
  ovle_ram #(.Width(AW), .Depth(Depth)) u_next_ram (
    .clk_i, .we_i(next_we), .waddr_i(next_waddr), .wdata_i(next_wdata),
    .raddr_i(rd_addr), .rdata_o(next_rd)
  );
  ovle_ram #(.Width(AW), .Depth(Depth)) u_prior_ram (
    .clk_i, .we_i(prior_we), .waddr_i(prior_waddr), .wdata_i(prior_wdata),
    .raddr_i(rd_addr), .rdata_o(prior_rd)
  );
  // free-slot stack: slots returned by removals
  ovle_ram #(.Width(AW), .Depth(Depth)) u_free_ram (
    .clk_i, .we_i(stk_we), .waddr_i(sp_q[AW-1:0]), .wdata_i(cur_q),
    .raddr_i(stk_raddr), .rdata_o(stk_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      sp_q     <= '0;
      fresh_q  <= '0;
      status_q <= ST_DONE;
      hit_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      sp_q     <= sp_d;
      fresh_q  <= fresh_d;
      status_q <= status_d;
      hit_q    <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_i;
      key_q  <= operand_value_i;
      newv_q <= new_value_i;
    end
    cur_q  <= cur_d;
    k_q    <= k_d;
    head_q <= head_d;
    tail_q <= tail_d;
  end

  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    k_d      = k_q;
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    sp_d     = sp_q;
    fresh_d  = fresh_q;
    status_d = status_q;
    hit_d    = hit_q;
    rd_addr  = cur_q;
    val_we   = 1'b0;
    val_waddr   = cur_q;
    val_wdata   = newv_q;
    next_we     = 1'b0;
    next_waddr  = prior_rd;
    next_wdata  = next_rd;
    prior_we    = 1'b0;
    prior_waddr = next_rd;
    prior_wdata = prior_rd;
    stk_we      = 1'b0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          status_d = ST_DONE;
          hit_d    = 1'b0;
          k_d      = '0;
          case (op_i)
            OP_APPEND: begin
              if (count_q == FULL_CNT) begin
                status_d = ST_FULL;
                state_d  = S_FIN;
              end else begin
                state_d = S_ALLOC;
              end
            end
            OP_REMOVE_HEAD, OP_REMOVE_TAIL,
            OP_DELETE_KEY, OP_FIND_KEY, OP_REPLACE_KEY: begin
              cur_d = (op_i == OP_REMOVE_TAIL) ? tail_q : head_q;
              if (empty) begin
                status_d = ST_EMPTY;
                state_d  = S_FIN;
              end else begin
                state_d = S_READ;
              end
            end
            default: state_d = S_FIN;
          endcase
        end
      end

      // free-stack top read in flight
      S_ALLOC: state_d = S_APPEND;

      S_APPEND: begin
        val_we      = 1'b1;
        val_waddr   = slot;
        val_wdata   = key_q;
        prior_we    = 1'b1;
        prior_waddr = slot;
        prior_wdata = tail_q;
        next_we     = !empty;
        next_waddr  = tail_q;
        next_wdata  = slot;
        if (empty) begin
          head_d = slot;
        end
        tail_d  = slot;
        count_d = count_q + ONE;
        if (sp_q != '0) begin
          sp_d = sp_q - ONE;
        end else begin
          fresh_d = fresh_q + ONE;
        end
        state_d = S_FIN;
      end

      S_READ: begin
        state_d = ((op_q == OP_REMOVE_HEAD) || (op_q == OP_REMOVE_TAIL)) ? S_UNLINK : S_CMP;
      end

      // one list entry compared per cycle; a miss chains the read to the next link
      S_CMP: begin
        if (match) begin
          hit_d = 1'b1;
          case (op_q)
            OP_DELETE_KEY:  state_d = S_UNLINK;
            OP_REPLACE_KEY: begin
              val_we  = 1'b1;
              state_d = S_FIN;
            end
            default: state_d = S_FIN;
          endcase
        end else if (last) begin
          status_d = ST_NOTFOUND;
          state_d  = S_FIN;
        end else begin
          rd_addr = next_rd;
          cur_d   = next_rd;
          k_d     = k_q + ONE;
        end
      end

      S_UNLINK: begin
        if (cur_q == head_q) begin
          head_d = next_rd;
        end else begin
          next_we = 1'b1;
        end
        if (cur_q == tail_q) begin
          tail_d = prior_rd;
        end else begin
          prior_we = 1'b1;
        end
        stk_we  = 1'b1;
        sp_d    = sp_q + ONE;
        count_d = count_q - ONE;
        state_d = S_FIN;
      end

      S_FIN: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign res_o.status = status_q;
  assign res_o.hit    = hit_q;
  assign res_o.count  = COUNT_OUT_W'(count_q);

endmodule

FILE: sv/ordered_value_list_engine_unit.sv
// Top level of the ordered value list engine: stream ports and output register.
// Depends on ovle_pkg, ovle_seq (which holds the RAMs built from ovle_ram).
//
// Keeps up to DEPTH signed 32-bit values as a doubly linked list in insertion
// order. Each input beat carries one operation (append, remove first, remove
// last, delete key, find key, replace key) and yields exactly one output beat
// with status (done, not found, empty, full), a hit flag and the entry count
// after the operation (low 5 bits). Codes six and seven do nothing and report
// done. One operation is worked at a time; s_axis_tready is high only while
// the sequencer is idle. Append passes through the allocate and append states,
// remove through the read and unlink states, find and replace through the read
// state and one compare step per entry walked, and delete through read, compare
// steps and unlink, before the result enters the output register. Refused
// appends, operations on an empty list and codes six and seven go straight to
// the result state. The sequencer is idle again the cycle after the result is
// loaded; a stalled output beat holds the sequencer in turn. The key walk
// follows the next links through the value/link RAM read port, one entry
// per cycle. A finished result sits in the output register, so the
// next beat can be accepted while the previous result waits. Freed slots go
// onto a free-slot stack; untouched slots are handed out by a fill count, so
// no clearing pass is needed after reset.
module ordered_value_list_engine_unit
  import ovle_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [2:0] operation, [34:3] operand_value, [66:35] new_value, [71:67] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [1:0] status, [2] hit, [7:3] entry_count
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic    res_valid, res_ready;
  result_t res;
  logic    m_valid_q;
  result_t m_data_q;

  ovle_seq #(.Depth(DEPTH)) u_seq (
    .clk_i,
    .rst_ni,
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .op_i            (op_e'(s_axis_tdata[OP_W-1:0])),
    .operand_value_i (s_axis_tdata[OP_W +: DATA_W]),
    .new_value_i     (s_axis_tdata[OP_W+DATA_W +: DATA_W]),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_o           (res)
  );

  // output register: loads when empty or being drained this cycle
  assign res_ready = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_ready) begin
      m_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      m_data_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_data_q.count, m_data_q.hit, m_data_q.status};

endmodule
